@@ hw/rtl/rgrc_pkg.sv @@
package rgrc_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M1,
    ST_M2,
    ST_DEC,
    ST_MUL5,
    ST_ADD,
    ST_DIV,
    ST_D,
    ST_G,
    ST_GCHK,
    ST_SCALE,
    ST_WIN
  } st_t;

  // item kinds
  localparam logic [1:0] OP_ACK   = 2'd0;
  localparam logic [1:0] OP_ENTER = 2'd1;

  // zones reported with each result
  localparam logic [2:0] ZN_NONE  = 3'd0;
  localparam logic [2:0] ZN_LOW   = 3'd1;
  localparam logic [2:0] ZN_HIGH  = 3'd2;
  localparam logic [2:0] ZN_RISE  = 3'd3;
  localparam logic [2:0] ZN_HYPER = 3'd4;
  localparam logic [2:0] ZN_FALL  = 3'd5;

  // register indexes
  localparam logic [2:0] REG_EWMA   = 3'd0;
  localparam logic [2:0] REG_BETA   = 3'd1;
  localparam logic [2:0] REG_STEP   = 3'd2;
  localparam logic [2:0] REG_HIGH   = 3'd3;
  localparam logic [2:0] REG_LOW    = 3'd4;
  localparam logic [2:0] REG_MINRTT = 3'd5;
  localparam logic [2:0] REG_START  = 3'd6;

  // register reset values
  localparam logic [15:0] DEF_EWMA   = 16'd6554;
  localparam logic [15:0] DEF_BETA   = 16'd52429;
  localparam logic [31:0] DEF_STEP   = 32'd65536;
  localparam logic [23:0] DEF_HIGH   = 24'd50000;
  localparam logic [23:0] DEF_LOW    = 24'd2000;
  localparam logic [23:0] DEF_MINRTT = 24'd2000;
  localparam logic [31:0] DEF_START  = 32'd65536;

  localparam logic [16:0] Q16_ONE      = 17'h10000;
  localparam logic [2:0]  HYPER_ROUNDS = 3'd5;
  localparam logic [24:0] HYPER_MULT   = 25'd5;

endpackage

@@ hw/rtl/rtt_gradient_rate_control.sv @@
// channel | dir | beat contents
// in_     | in  | tdata: rtt_us[23:0] acked_seq[55:24] next_tx_seq[87:56]; tuser: opcode[1:0]
// out_    | out | tdata: cwnd_bytes[31:0]; tuser: updated[0] zone[3:1]
// cfg_    | in  | cfg_addr register index, cfg_data value (low bits used)
//
// an item that adjusts nothing goes straight to the window step; a round first updates the average,
// then adds a step (low, rise, hyperactive), divides and scales (high, gradient fall) or wipes the rate:
// a 16-step restoring divider and one shared 33x25 multiplier run each step in turn
// in_tready is high only while the sequencer is idle; a result waits in the output
// register and the next item is taken meanwhile; the window step holds while it waits
// rst_n is synchronous; registers return to their defaults, rate to the default start
module rtt_gradient_rate_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // rtt_us, acked_seq, next_tx_seq
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cwnd_bytes
  output logic [3:0]  out_tuser,  // updated, zone
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [15:0] ewma_r, beta_r;
  logic [31:0] step_cfg_r;
  logic [23:0] high_r, low_r, minrtt_r;

  // control state
  rgrc_pkg::st_t state_r, state_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] avg_r, avg_nxt;            // signed q8
  logic [23:0] prev_rtt_r, prev_rtt_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  logic [2:0]  rise_r, rise_nxt;
  logic [31:0] edge_r, edge_nxt;
  logic        ctl_on_r, ctl_on_nxt;
  logic [23:0] last_rtt_r, last_rtt_nxt;

  // working registers
  logic [23:0] new_rtt_r, new_rtt_nxt;
  logic [24:0] diff_r, diff_nxt;
  logic [50:0] acc_r, acc_nxt;
  logic [34:0] step_r, step_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [23:0] dvs_r, dvs_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [16:0] fac_r, fac_nxt;
  logic [2:0]  zone_r, zone_nxt;
  logic        upd_r, upd_nxt;

  // output register
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] ocwnd_r, ocwnd_nxt;
  logic [3:0]  ouser_r, ouser_nxt;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod;
  assign prod = mul_a * mul_b;

  logic [23:0] min_eff;
  assign min_eff = (minrtt_r == 24'd0) ? 24'd1 : minrtt_r;

  logic [1:0]  opcode;
  logic [23:0] in_rtt;
  logic [31:0] in_acked, in_next;
  assign opcode   = in_tuser;
  assign in_rtt   = in_tdata[23:0];
  assign in_acked = in_tdata[55:24];
  assign in_next  = in_tdata[87:56];

  logic [31:0] seq_gap;
  assign seq_gap = in_acked - edge_r;

  // locals of the combinational block
  logic [23:0] smp;
  logic [50:0] sum;
  logic [34:0] shd;
  logic [35:0] radd;
  logic [24:0] trial;
  logic        ge;
  logic [39:0] win;

  assign in_tready  = (state_r == rgrc_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = ocwnd_r;
  assign out_tuser  = ouser_r;

  always_comb begin
    state_nxt      = state_r;
    rate_nxt       = rate_r;
    avg_nxt        = avg_r;
    prev_rtt_nxt   = prev_rtt_r;
    prev_valid_nxt = prev_valid_r;
    rise_nxt       = rise_r;
    edge_nxt       = edge_r;
    ctl_on_nxt     = ctl_on_r;
    last_rtt_nxt   = last_rtt_r;
    new_rtt_nxt    = new_rtt_r;
    diff_nxt       = diff_r;
    acc_nxt        = acc_r;
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    cnt_nxt        = cnt_r;
    fac_nxt        = fac_r;
    zone_nxt       = zone_r;
    upd_nxt        = upd_r;
    ovalid_nxt     = ovalid_r & ~out_tready;
    ocwnd_nxt      = ocwnd_r;
    ouser_nxt      = ouser_r;
    mul_a          = '0;
    mul_b          = '0;
    smp            = (in_rtt != 24'd0) ? in_rtt : last_rtt_r;
    sum            = '0;
    shd            = '0;
    radd           = '0;
    trial          = {rem_r, quo_r[15]};
    ge             = (trial >= {1'b0, dvs_r});
    win            = '0;

    unique case (state_r)
      rgrc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          upd_nxt   = 1'b0;
          zone_nxt  = rgrc_pkg::ZN_NONE;
          state_nxt = rgrc_pkg::ST_WIN;
          priority if (opcode == rgrc_pkg::OP_ACK) begin
            last_rtt_nxt = smp;
            if (ctl_on_r && !seq_gap[31]) begin
              // round closed
              edge_nxt       = in_next;
              new_rtt_nxt    = smp;
              diff_nxt       = prev_valid_r ? ({1'b0, smp} - {1'b0, prev_rtt_r}) : 25'd0;
              prev_rtt_nxt   = smp;
              prev_valid_nxt = 1'b1;
              upd_nxt        = 1'b1;
              state_nxt      = rgrc_pkg::ST_M1;
            end
          end else if (opcode == rgrc_pkg::OP_ENTER) begin
            ctl_on_nxt = 1'b1;
            edge_nxt   = in_next;
          end else begin
            ctl_on_nxt = 1'b0;
          end
        end
      end
      rgrc_pkg::ST_M1: begin
        // (1 - alpha) * avg
        mul_a     = {avg_r[31], avg_r};
        mul_b     = {8'd0, rgrc_pkg::Q16_ONE - {1'b0, ewma_r}};
        acc_nxt   = {prod[49], prod[49:0]};
        state_nxt = rgrc_pkg::ST_M2;
      end
      rgrc_pkg::ST_M2: begin
        // + alpha * diff * 256, floor to q8, saturate
        mul_a = {{8{diff_r[24]}}, diff_r};
        mul_b = {9'd0, ewma_r};
        sum   = acc_r + {{2{prod[40]}}, prod[40:0], 8'd0};
        shd   = sum[50:16];
        if (shd[34:31] == {4{shd[34]}})
          avg_nxt = shd[31:0];
        else
          avg_nxt = shd[34] ? 32'h8000_0000 : 32'h7fff_ffff;
        state_nxt = rgrc_pkg::ST_DEC;
      end
      rgrc_pkg::ST_DEC: begin
        priority if (new_rtt_r < low_r) begin
          rise_nxt  = '0;
          step_nxt  = {3'd0, step_cfg_r};
          zone_nxt  = rgrc_pkg::ZN_LOW;
          state_nxt = rgrc_pkg::ST_ADD;
        end else if (new_rtt_r > high_r) begin
          // f = high * 2^16 / new_rtt, quotient below 2^16
          rise_nxt  = '0;
          rem_nxt   = high_r;
          quo_nxt   = '0;
          dvs_nxt   = new_rtt_r;
          cnt_nxt   = '0;
          zone_nxt  = rgrc_pkg::ZN_HIGH;
          state_nxt = rgrc_pkg::ST_DIV;
        end else if (avg_r[31] || avg_r == 32'd0) begin
          if (rise_r + 3'd1 >= rgrc_pkg::HYPER_ROUNDS) begin
            rise_nxt  = '0;
            zone_nxt  = rgrc_pkg::ZN_HYPER;
            state_nxt = rgrc_pkg::ST_MUL5;
          end else begin
            rise_nxt  = rise_r + 3'd1;
            step_nxt  = {3'd0, step_cfg_r};
            zone_nxt  = rgrc_pkg::ZN_RISE;
            state_nxt = rgrc_pkg::ST_ADD;
          end
        end else begin
          rise_nxt  = '0;
          zone_nxt  = rgrc_pkg::ZN_FALL;
          state_nxt = rgrc_pkg::ST_G;
        end
      end
      rgrc_pkg::ST_MUL5: begin
        mul_a     = {1'b0, step_cfg_r};
        mul_b     = rgrc_pkg::HYPER_MULT;
        step_nxt  = prod[34:0];
        state_nxt = rgrc_pkg::ST_ADD;
      end
      rgrc_pkg::ST_ADD: begin
        radd      = {4'd0, rate_r} + {1'b0, step_r};
        rate_nxt  = (radd[35:32] != 4'd0) ? 32'hffff_ffff : radd[31:0];
        state_nxt = rgrc_pkg::ST_WIN;
      end
      rgrc_pkg::ST_DIV: begin
        // one restoring step per cycle, quotient shifts in behind the dividend
        rem_nxt = ge ? 24'(trial - {1'b0, dvs_r}) : trial[23:0];
        quo_nxt = {quo_r[14:0], ge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          if (zone_r == rgrc_pkg::ZN_HIGH) begin
            state_nxt = rgrc_pkg::ST_D;
          end else begin
            fac_nxt   = rgrc_pkg::Q16_ONE - {1'b0, quo_nxt};
            state_nxt = rgrc_pkg::ST_SCALE;
          end
        end
      end
      rgrc_pkg::ST_D: begin
        // d = beta * (1 - f)
        mul_a     = {16'd0, rgrc_pkg::Q16_ONE - {1'b0, quo_r}};
        mul_b     = {9'd0, beta_r};
        fac_nxt   = rgrc_pkg::Q16_ONE - {1'b0, prod[31:16]};
        state_nxt = rgrc_pkg::ST_SCALE;
      end
      rgrc_pkg::ST_G: begin
        // beta * avg / 256, avg positive here
        mul_a     = {avg_r[31], avg_r};
        mul_b     = {9'd0, beta_r};
        acc_nxt   = {12'd0, prod[46:8]};
        state_nxt = rgrc_pkg::ST_GCHK;
      end
      rgrc_pkg::ST_GCHK: begin
        if (acc_r[39:0] >= {min_eff, 16'd0}) begin
          // gradient of one or more wipes the rate
          rate_nxt  = '0;
          state_nxt = rgrc_pkg::ST_WIN;
        end else begin
          rem_nxt   = {1'b0, acc_r[38:16]};
          quo_nxt   = acc_r[15:0];
          dvs_nxt   = min_eff;
          cnt_nxt   = '0;
          state_nxt = rgrc_pkg::ST_DIV;
        end
      end
      rgrc_pkg::ST_SCALE: begin
        mul_a     = {1'b0, rate_r};
        mul_b     = {8'd0, fac_r};
        rate_nxt  = prod[47:16];
        state_nxt = rgrc_pkg::ST_WIN;
      end
      rgrc_pkg::ST_WIN: begin
        mul_a = {1'b0, rate_r};
        mul_b = {1'b0, min_eff};
        win   = prod[55:16];
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          ocwnd_nxt  = (win[39:32] != 8'd0) ? 32'hffff_ffff : win[31:0];
          ouser_nxt  = {zone_r, upd_r};
          state_nxt  = rgrc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rgrc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rgrc_pkg::ST_IDLE;
      rate_r       <= rgrc_pkg::DEF_START;
      avg_r        <= '0;
      prev_rtt_r   <= '0;
      prev_valid_r <= 1'b0;
      rise_r       <= '0;
      edge_r       <= '0;
      ctl_on_r     <= 1'b1;
      last_rtt_r   <= '0;
      ovalid_r     <= 1'b0;
      ewma_r       <= rgrc_pkg::DEF_EWMA;
      beta_r       <= rgrc_pkg::DEF_BETA;
      step_cfg_r   <= rgrc_pkg::DEF_STEP;
      high_r       <= rgrc_pkg::DEF_HIGH;
      low_r        <= rgrc_pkg::DEF_LOW;
      minrtt_r     <= rgrc_pkg::DEF_MINRTT;
    end else begin
      state_r      <= state_nxt;
      rate_r       <= rate_nxt;
      avg_r        <= avg_nxt;
      prev_rtt_r   <= prev_rtt_nxt;
      prev_valid_r <= prev_valid_nxt;
      rise_r       <= rise_nxt;
      edge_r       <= edge_nxt;
      ctl_on_r     <= ctl_on_nxt;
      last_rtt_r   <= last_rtt_nxt;
      ovalid_r     <= ovalid_nxt;
      if (cfg_valid) begin
        unique case (cfg_addr)
          rgrc_pkg::REG_EWMA:   ewma_r     <= cfg_data[15:0];
          rgrc_pkg::REG_BETA:   beta_r     <= cfg_data[15:0];
          rgrc_pkg::REG_STEP:   step_cfg_r <= cfg_data;
          rgrc_pkg::REG_HIGH:   high_r     <= cfg_data[23:0];
          rgrc_pkg::REG_LOW:    low_r      <= cfg_data[23:0];
          rgrc_pkg::REG_MINRTT: minrtt_r   <= cfg_data[23:0];
          rgrc_pkg::REG_START:  ;  // start rate is reloaded only by reset, at its default
          default: ;
        endcase
      end
    end
  end

  // working and payload registers, no reset
  always_ff @(posedge clk) begin
    new_rtt_r <= new_rtt_nxt;
    diff_r    <= diff_nxt;
    acc_r     <= acc_nxt;
    step_r    <= step_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    dvs_r     <= dvs_nxt;
    cnt_r     <= cnt_nxt;
    fac_r     <= fac_nxt;
    zone_r    <= zone_nxt;
    upd_r     <= upd_nxt;
    ocwnd_r   <= ocwnd_nxt;
    ouser_r   <= ouser_nxt;
  end

endmodule
